>>> hdl/shutter_motor_controller_core_macros.svh
// Assertion macros shared by the shutter motor controller checker.
`ifndef SHUTTER_MOTOR_CONTROLLER_CORE_MACROS_SVH
`define SHUTTER_MOTOR_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SMC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smc assertion failed");

`endif

>>> hdl/smc_pkg.sv
// Shared types, codes and register defaults for the shutter motor controller.
package smc_pkg;

  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_UP   = 2'd1,
    MODE_DOWN = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REQ_NONE = 2'd0,
    REQ_STOP = 2'd1,
    REQ_UP   = 2'd2,
    REQ_DOWN = 2'd3
  } req_t;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_POLL_INTERVAL = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MIN_RUN       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_RUN       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_STALL_LIMIT   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_POWER_DELTA   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TEMP_DELTA    = 3'd5;

  localparam logic [15:0] POLL_INTERVAL_RST = 16'd500;
  localparam logic [15:0] MIN_RUN_RST       = 16'd500;
  localparam logic [31:0] MAX_RUN_RST       = 32'd120000;
  localparam logic [15:0] STALL_LIMIT_RST   = 16'd100;
  localparam logic [15:0] POWER_DELTA_RST   = 16'd20;
  localparam logic [10:0] TEMP_DELTA_RST    = 11'd10;

  localparam int InDataW = 64;
  localparam int OutDataW = 40;

endpackage

>>> hdl/shutter_motor_controller_core.sv
// Shutter motor controller: button/remote mode control, relay sequencing and reports.
//
// Takes one tick request per clock and returns exactly one result request per tick.
// Each tick is processed by combinational logic from the incoming request into the
// output register; in_tready stays high unless the output register holds a result
// that out_tready has not taken, so throughput is one tick per cycle while the output
// is not stalled. A poll runs when the modular time since the last poll
// reaches poll_interval_ms: the buttons are evaluated, the relays step toward the
// requested mode (a reversal rests in stop for one poll), power and temperature
// are reported on a change of at least their delta, and low power after min_run_ms
// stops the motor. Every tick also stops the motor once it has run max_run_ms.
// Configuration writes take effect on the next tick and are legal only when idle.
module shutter_motor_controller_core
  import smc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // time_ms[31:0], req_type[33:32], up_button[34], down_button[35],
  // power_sample[51:36], temperature_sample[62:52], zero[63]
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  // up_relay[0], down_relay[1], requested_mode[3:2], power_report_valid[4],
  // power_reported[20:5], temp_report_valid[21], temp_reported[32:22], zero[39:33]
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  // configuration
  logic [15:0] poll_interval_r, min_run_r, stall_limit_r, power_delta_r;
  logic [31:0] max_run_r;
  logic [10:0] temp_delta_r;

  // controller state
  mode_t              wanted_r, wanted_nxt;
  mode_t              applied_r, applied_nxt;
  logic               prev_up_r, prev_up_nxt;
  logic               prev_down_r, prev_down_nxt;
  logic [31:0]        run_start_r, run_start_nxt;
  logic               running_r, running_nxt;
  logic [31:0]        last_poll_r, last_poll_nxt;
  logic [15:0]        last_power_r, last_power_nxt;
  logic signed [10:0] last_temp_r, last_temp_nxt;

  logic                out_valid_r;
  logic [OutDataW-1:0] out_data_r, out_data_nxt;

  // unpacked request fields
  logic [31:0]        now;
  req_t               req;
  logic               up_btn, down_btn;
  logic [15:0]        power;
  logic signed [10:0] temp;

  logic               poll, starting;
  logic [31:0]        elapsed;
  logic [15:0]        pdiff;
  logic signed [11:0] tdiff;
  logic [11:0]        tabs;
  logic               pvalid, tvalid;
  logic               accept;

  assign now      = in_tdata[31:0];
  assign req      = req_t'(in_tdata[33:32]);
  assign up_btn   = in_tdata[34];
  assign down_btn = in_tdata[35];
  assign power    = in_tdata[51:36];
  assign temp     = in_tdata[62:52];

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    wanted_nxt     = wanted_r;
    applied_nxt    = applied_r;
    prev_up_nxt    = prev_up_r;
    prev_down_nxt  = prev_down_r;
    run_start_nxt  = run_start_r;
    running_nxt    = running_r;
    last_poll_nxt  = last_poll_r;
    last_power_nxt = last_power_r;
    last_temp_nxt  = last_temp_r;
    starting       = 1'b0;
    pvalid         = 1'b0;
    tvalid         = 1'b0;

    case (req)
      REQ_STOP: wanted_nxt = MODE_STOP;
      REQ_UP:   wanted_nxt = MODE_UP;
      REQ_DOWN: wanted_nxt = MODE_DOWN;
      default:  ;
    endcase

    poll  = (now - last_poll_r) >= {16'd0, poll_interval_r};
    pdiff = (power >= last_power_r) ? (power - last_power_r) : (last_power_r - power);
    tdiff = {temp[10], temp} - {last_temp_r[10], last_temp_r};
    tabs  = tdiff[11] ? 12'(-tdiff) : 12'(tdiff);

    if (poll) begin
      last_poll_nxt = now;

      // buttons: both pressed stops; a new press starts, holding keeps, else stop
      if (up_btn && down_btn) begin
        wanted_nxt = MODE_STOP;
      end else if (up_btn) begin
        if ((wanted_nxt == MODE_STOP && !prev_up_r) || (wanted_nxt == MODE_UP && prev_up_r))
          wanted_nxt = MODE_UP;
        else
          wanted_nxt = MODE_STOP;
      end else if (down_btn) begin
        if ((wanted_nxt == MODE_STOP && !prev_down_r) ||
            (wanted_nxt == MODE_DOWN && prev_down_r))
          wanted_nxt = MODE_DOWN;
        else
          wanted_nxt = MODE_STOP;
      end
      prev_up_nxt   = up_btn;
      prev_down_nxt = down_btn;

      // relays: any change out of a running direction goes through stop first
      if (wanted_nxt != applied_r) begin
        if (wanted_nxt == MODE_STOP || applied_r != MODE_STOP) begin
          applied_nxt   = MODE_STOP;
          running_nxt   = 1'b0;
          run_start_nxt = '0;
        end else begin
          applied_nxt   = wanted_nxt;
          running_nxt   = 1'b1;
          run_start_nxt = now;
          starting      = 1'b1;
        end
      end

      if (pdiff >= power_delta_r) begin
        last_power_nxt = power;
        pvalid         = 1'b1;
      end

      if (tabs >= {1'b0, temp_delta_r}) begin
        last_temp_nxt = temp;
        tvalid        = 1'b1;
      end
    end

    // run time measured from the start recorded by this tick's relay step
    elapsed = starting ? 32'd0 : (now - run_start_r);

    if (poll && power < stall_limit_r && running_nxt && elapsed >= {16'd0, min_run_r})
      wanted_nxt = MODE_STOP;

    if (running_nxt && elapsed >= max_run_r)
      wanted_nxt = MODE_STOP;

    out_data_nxt = {
      7'd0,
      tvalid ? temp : 11'sd0,
      tvalid,
      pvalid ? power : 16'd0,
      pvalid,
      wanted_nxt,
      applied_nxt == MODE_DOWN,
      applied_nxt == MODE_UP
    };
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_interval_r <= POLL_INTERVAL_RST;
      min_run_r       <= MIN_RUN_RST;
      max_run_r       <= MAX_RUN_RST;
      stall_limit_r   <= STALL_LIMIT_RST;
      power_delta_r   <= POWER_DELTA_RST;
      temp_delta_r    <= TEMP_DELTA_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_POLL_INTERVAL: poll_interval_r <= cfg_wdata[15:0];
        REG_MIN_RUN:       min_run_r       <= cfg_wdata[15:0];
        REG_MAX_RUN:       max_run_r       <= cfg_wdata[31:0];
        REG_STALL_LIMIT:   stall_limit_r   <= cfg_wdata[15:0];
        REG_POWER_DELTA:   power_delta_r   <= cfg_wdata[15:0];
        REG_TEMP_DELTA:    temp_delta_r    <= cfg_wdata[10:0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_r     <= MODE_STOP;
      applied_r    <= MODE_STOP;
      prev_up_r    <= 1'b0;
      prev_down_r  <= 1'b0;
      run_start_r  <= '0;
      running_r    <= 1'b0;
      last_poll_r  <= '0;
      last_power_r <= '0;
      last_temp_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        wanted_r     <= wanted_nxt;
        applied_r    <= applied_nxt;
        prev_up_r    <= prev_up_nxt;
        prev_down_r  <= prev_down_nxt;
        run_start_r  <= run_start_nxt;
        running_r    <= running_nxt;
        last_poll_r  <= last_poll_nxt;
        last_power_r <= last_power_nxt;
        last_temp_r  <= last_temp_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

>>> hdl/smc_checker.sv
// Port-level checker for the shutter motor controller, bound to the controller core.
`include "shutter_motor_controller_core_macros.svh"

module smc_checker
  import smc_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic [OutDataW-1:0] out_tdata,
  input logic                out_tvalid,
  input logic                out_tready
);

  // never drive both relays at once
  `SMC_ASSERT_NOW(a_relay_excl, clk, rst_n, out_tvalid, !(out_tdata[0] && out_tdata[1]))

  // report values are zero whenever both valid flags are clear
  `SMC_ASSERT_NOW(a_no_report_zero, clk, rst_n, out_tvalid && !out_tdata[4] && !out_tdata[21],
                  out_tdata[20:5] == 16'd0 && out_tdata[32:22] == 11'd0)

  // an accepted request shows up as a result next cycle
  `SMC_ASSERT_NXT(a_result_follows, clk, rst_n, in_tvalid && in_tready, out_tvalid)

  // a stalled result holds its data
  `SMC_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                  out_tvalid && $stable(out_tdata))

endmodule

bind shutter_motor_controller_core smc_checker u_smc_checker (.*);
